// File: src/iir4_pkg.sv
package iir4_pkg;

   // Field and datapath widths
   localparam int SampleWidth = 16;
   localparam int CoeffWidth  = 16;
   localparam int AccWidth    = 32;
   localparam int DigitWidth  = 4;
   localparam int NumDigits   = CoeffWidth / DigitWidth;
   localparam int CsrWidth    = 64;
   localparam int CsrIdxWidth = 2;

   // Configuration register indexes
   localparam logic [CsrIdxWidth-1:0] CSR_FEEDBACK     = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_FORWARD_LOW  = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_FORWARD_LAST = 2'd2;

   // Register defaults (coefficients at half scale)
   localparam logic [CsrWidth-1:0]   FEEDBACK_RESET     = 64'd166357368343889720;
   localparam logic [CsrWidth-1:0]   FORWARD_LOW_RESET  = 64'd1181937732703159856;
   localparam logic [CoeffWidth-1:0] FORWARD_LAST_RESET = 16'd1584;

   // Control from the sequencer to the shared multiply-accumulate unit
   typedef struct packed {
      logic mul_en;     // advance the digit-serial product
      logic first;      // current digit is the signed most significant one
      logic acc_en;     // fold the finished product into the accumulator
      logic acc_sub;    // subtract instead of add
      logic acc_load;   // load the accumulator with the scaled input
      logic acc_clear;  // clear the accumulator
   } mac_ctrl_type;

endpackage

// File: src/iir4_if.sv
interface iir4_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [iir4_pkg::SampleWidth-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

interface iir4_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [iir4_pkg::SampleWidth-1:0] sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

// File: src/iir4_mac.sv
module iir4_mac (
   input  logic                                   clock,
   input  logic                                   reset,
   input  iir4_pkg::mac_ctrl_type                 ctrl,
   input  logic [iir4_pkg::DigitWidth-1:0]        digit,
   input  logic signed [iir4_pkg::SampleWidth-1:0] data,
   input  logic signed [iir4_pkg::AccWidth-1:0]   load_val,
   output logic signed [iir4_pkg::SampleWidth-1:0] rounded
);

   localparam int ProdWidth = iir4_pkg::DigitWidth + 1 + iir4_pkg::SampleWidth;
   localparam int AccW      = iir4_pkg::AccWidth;

   logic signed [iir4_pkg::DigitWidth:0] digit_s;
   logic signed [ProdWidth-1:0]          digit_prod;
   logic signed [AccW-1:0]               pp_ff, pp_in;
   logic signed [AccW-1:0]               acc_ff, acc_in;
   logic signed [AccW-1:0]               frac;
   logic signed [AccW:0]                 sum;
   logic signed [AccW-1:0]               sum_sat;
   logic signed [AccW:0]                 rnd;
   logic signed [iir4_pkg::SampleWidth-1:0] hi;

   // Multiply one coefficient digit, most significant (signed) digit first
   always_comb begin
      digit_s    = ctrl.first ? {digit[iir4_pkg::DigitWidth-1], digit} : {1'b0, digit};
      digit_prod = digit_s * data;
      if (ctrl.first) begin
         pp_in = AccW'(digit_prod);
      end else begin
         pp_in = (pp_ff <<< iir4_pkg::DigitWidth) + AccW'(digit_prod);
      end
   end

   // Double the finished product, saturating the one overflow case, and add or subtract it with saturation
   always_comb begin
      if (pp_ff == {2'b01, {(AccW-2){1'b0}}}) begin
         frac = {1'b0, {(AccW-1){1'b1}}};
      end else begin
         frac = pp_ff <<< 1;
      end
      if (ctrl.acc_sub) begin
         sum = {acc_ff[AccW-1], acc_ff} - {frac[AccW-1], frac};
      end else begin
         sum = {acc_ff[AccW-1], acc_ff} + {frac[AccW-1], frac};
      end
      if (sum[AccW] != sum[AccW-1]) begin
         sum_sat = sum[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
      end else begin
         sum_sat = sum[AccW-1:0];
      end
   end

   // Round to the high half, then double with saturation
   always_comb begin
      rnd = {acc_ff[AccW-1], acc_ff} + (AccW+1)'(33'sh0_8000);
      if (rnd[AccW] != rnd[AccW-1]) begin
         hi = {1'b0, {(iir4_pkg::SampleWidth-1){1'b1}}};
      end else begin
         hi = rnd[AccW-1:AccW-iir4_pkg::SampleWidth];
      end
      if (hi[iir4_pkg::SampleWidth-1] != hi[iir4_pkg::SampleWidth-2]) begin
         rounded = hi[iir4_pkg::SampleWidth-1]
                 ? {1'b1, {(iir4_pkg::SampleWidth-1){1'b0}}}
                 : {1'b0, {(iir4_pkg::SampleWidth-1){1'b1}}};
      end else begin
         rounded = {hi[iir4_pkg::SampleWidth-2:0], 1'b0};
      end
   end

   // Select the next accumulator value
   always_comb begin
      priority if (ctrl.acc_load) begin
         acc_in = load_val;
      end else if (ctrl.acc_clear) begin
         acc_in = '0;
      end else if (ctrl.acc_en) begin
         acc_in = sum_sat;
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         pp_ff <= pp_in;
      end
   end

endmodule

// File: src/iir_fourth_order_df2_q15.sv
// Fourth-order direct form II IIR filter, Q15, saturating arithmetic.
// req: one transaction carries one input sample (sample_in); it is taken
//   when req.valid and req.ready are high at a rising clock edge.
// rsp: one transaction carries one filtered sample (sample_out) per input.
// csr: csr_we writes csr_wdata into register csr_index at the clock edge:
//   0 feedback coefficients a1..a4, 1 feedforward b0..b3, 2 feedforward b4.
//   Write only while the filter is idle.
// One shared multiply-accumulate unit does all nine products, consuming the
// coefficient four bits a cycle from a shift register. A new sample is taken
// only once the previous one has passed its final rounding step and the
// filter is idle again.
// The result sits in an output register; the next sample is accepted while
// it waits. If the receiver stalls, the following result holds in the final
// rounding step until the output register is free.
// Reset (synchronous, active high) clears the delay line, loads the
// default coefficients and empties the output register.
module iir_fourth_order_df2_q15 (
   input  logic                                    clock,
   input  logic                                    reset,
   iir4_req_if.sink                                req,
   iir4_rsp_if.source                              rsp,
   input  logic                                    csr_we,
   input  logic [iir4_pkg::CsrIdxWidth-1:0]        csr_index,
   input  logic [iir4_pkg::CsrWidth-1:0]           csr_wdata
);

   localparam int SW = iir4_pkg::SampleWidth;
   localparam int CW = iir4_pkg::CoeffWidth;
   localparam int DW = iir4_pkg::DigitWidth;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_FB      = 3'd1;
   localparam logic [2:0] ST_FB_ACC  = 3'd2;
   localparam logic [2:0] ST_ROUND_W = 3'd3;
   localparam logic [2:0] ST_FF      = 3'd4;
   localparam logic [2:0] ST_FF_ACC  = 3'd5;
   localparam logic [2:0] ST_ROUND_Y = 3'd6;

   localparam logic [1:0] LAST_DIGIT = 2'(iir4_pkg::NumDigits - 1);
   localparam logic [2:0] LAST_FB    = 3'd3;
   localparam logic [2:0] LAST_FF    = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [2:0]  term_ff, term_in;
   logic [1:0]  digit_ff, digit_in;
   logic [CW-1:0] coef_sr_ff, coef_sr_in;
   logic signed [SW-1:0] data_ff, data_in;
   logic signed [SW-1:0] w_ff, w_in;
   logic signed [SW-1:0] delay_ff [4];
   logic        shift_delay;
   logic [iir4_pkg::CsrWidth-1:0] fb_coef_ff, fwd_coef_ff;
   logic [CW-1:0]                 fwd_last_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic signed [SW-1:0] rsp_data_ff, rsp_data_in;
   logic        out_free;
   logic signed [SW-1:0] rounded;
   logic signed [iir4_pkg::AccWidth-1:0] load_val;
   iir4_pkg::mac_ctrl_type ctrl;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fb_coef_ff  <= iir4_pkg::FEEDBACK_RESET;
         fwd_coef_ff <= iir4_pkg::FORWARD_LOW_RESET;
         fwd_last_ff <= iir4_pkg::FORWARD_LAST_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            iir4_pkg::CSR_FEEDBACK:     fb_coef_ff  <= csr_wdata;
            iir4_pkg::CSR_FORWARD_LOW:  fwd_coef_ff <= csr_wdata;
            iir4_pkg::CSR_FORWARD_LAST: fwd_last_ff <= csr_wdata[CW-1:0];
            default: ;
         endcase
      end
   end

   assign req.ready  = (state_ff == ST_IDLE);
   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign load_val   = {req.sample_in[SW-1], req.sample_in[SW-1:1], {SW{1'b0}}};

   // Sequence the nine products and two rounding steps
   always_comb begin
      state_in     = state_ff;
      term_in      = term_ff;
      digit_in     = digit_ff;
      coef_sr_in   = coef_sr_ff;
      data_in      = data_ff;
      w_in         = w_ff;
      shift_delay  = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_data_in  = rsp_data_ff;
      ctrl         = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               ctrl.acc_load = 1'b1;
               coef_sr_in    = fb_coef_ff[CW-1:0];
               data_in       = delay_ff[0];
               term_in       = '0;
               digit_in      = '0;
               state_in      = ST_FB;
            end
         end
         ST_FB, ST_FF: begin
            ctrl.mul_en  = 1'b1;
            ctrl.first   = (digit_ff == '0);
            ctrl.acc_en  = (digit_ff == '0) && (term_ff != '0);
            ctrl.acc_sub = (state_ff == ST_FB);
            coef_sr_in   = coef_sr_ff << DW;
            digit_in     = digit_ff + 2'd1;
            if (digit_ff == LAST_DIGIT) begin
               term_in = term_ff + 3'd1;
               if (state_ff == ST_FB) begin
                  if (term_ff == LAST_FB) begin
                     state_in = ST_FB_ACC;
                  end else begin
                     coef_sr_in = fb_coef_ff[CW*term_in[1:0] +: CW];
                     data_in    = delay_ff[term_in[1:0]];
                  end
               end else begin
                  if (term_ff == LAST_FF) begin
                     state_in = ST_FF_ACC;
                  end else begin
                     // b1..b3 come from the low word, b4 from its own register
                     coef_sr_in = (term_in == LAST_FF) ? fwd_last_ff
                                : fwd_coef_ff[CW*term_in[1:0] +: CW];
                     data_in    = delay_ff[term_ff[1:0]];
                  end
               end
            end
         end
         ST_FB_ACC: begin
            ctrl.acc_en  = 1'b1;
            ctrl.acc_sub = 1'b1;
            state_in     = ST_ROUND_W;
         end
         ST_ROUND_W: begin
            ctrl.acc_clear = 1'b1;
            w_in           = rounded;
            data_in        = rounded;
            coef_sr_in     = fwd_coef_ff[CW-1:0];
            term_in        = '0;
            digit_in       = '0;
            state_in       = ST_FF;
         end
         ST_FF_ACC: begin
            ctrl.acc_en = 1'b1;
            state_in    = ST_ROUND_Y;
         end
         ST_ROUND_Y: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = rounded;
               shift_delay  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   iir4_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .digit    (coef_sr_ff[CW-1 -: DW]),
      .data     (data_ff),
      .load_val (load_val),
      .rounded  (rounded)
   );

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         term_ff      <= '0;
         digit_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         term_ff      <= term_in;
         digit_ff     <= digit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Delay line: advance once per finished sample
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff[0] <= '0;
         delay_ff[1] <= '0;
         delay_ff[2] <= '0;
         delay_ff[3] <= '0;
      end else if (shift_delay) begin
         delay_ff[0] <= w_ff;
         delay_ff[1] <= delay_ff[0];
         delay_ff[2] <= delay_ff[1];
         delay_ff[3] <= delay_ff[2];
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      coef_sr_ff  <= coef_sr_in;
      data_ff     <= data_in;
      w_ff        <= w_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.sample_out = rsp_data_ff;

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps

// Shapes of a set of four coefficients
typedef enum int {
   COEF_MAX,
   COEF_MIN,
   COEF_ZERO,
   COEF_WIDE,
   COEF_MILD
} coef_mode_type;

// Tracks the filter: predicts each output sample from the accepted input
// and the current coefficients, and holds the outputs still owed.
class df2_tracker_type;
   logic signed [iir4_pkg::CoeffWidth-1:0]  fb_coef [4];
   logic signed [iir4_pkg::CoeffWidth-1:0]  ff_coef [5];
   logic signed [iir4_pkg::SampleWidth-1:0] taps [4];
   logic signed [iir4_pkg::SampleWidth-1:0] expected_q [$];
   int unsigned                             errors;

   function new();
      for (int k = 0; k < 4; k++) begin
         fb_coef[k] = iir4_pkg::FEEDBACK_RESET[16*k +: 16];
         ff_coef[k] = iir4_pkg::FORWARD_LOW_RESET[16*k +: 16];
         taps[k]    = '0;
      end
      ff_coef[4] = iir4_pkg::FORWARD_LAST_RESET;
      errors     = 0;
   endfunction

   // Mirror a register write; unknown indexes and upper bits drop out
   function void write_reg(logic [iir4_pkg::CsrIdxWidth-1:0] idx,
                           logic [iir4_pkg::CsrWidth-1:0] data);
      case (idx)
         iir4_pkg::CSR_FEEDBACK: begin
            for (int k = 0; k < 4; k++) fb_coef[k] = data[16*k +: 16];
         end
         iir4_pkg::CSR_FORWARD_LOW: begin
            for (int k = 0; k < 4; k++) ff_coef[k] = data[16*k +: 16];
         end
         iir4_pkg::CSR_FORWARD_LAST: begin
            ff_coef[4] = data[iir4_pkg::CoeffWidth-1:0];
         end
         default: ;
      endcase
   endfunction

   function longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function int clip16(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // Fractional multiply, doubled and saturated
   function longint fmul(int a, int b);
      return clip32(longint'(a) * longint'(b) * 2);
   endfunction

   // Round into the high half with saturation
   function int round_high(longint acc);
      longint t;
      t = clip32(acc + 32768);
      return int'(t >>> 16);
   endfunction

   function void note_sample(logic signed [iir4_pkg::SampleWidth-1:0] x);
      longint acc;
      int     w;
      int     y;
      logic signed [iir4_pkg::SampleWidth-1:0] halved;
      halved = x >>> 1;
      acc = longint'(halved) * 65536;
      // feedback path gives the new delay value
      for (int k = 0; k < 4; k++) acc = clip32(acc - fmul(fb_coef[k], taps[k]));
      w = clip16(round_high(acc) * 2);
      // feedforward path over the new value and the old taps
      acc = fmul(ff_coef[0], w);
      for (int k = 1; k < 4; k++) acc = clip32(acc + fmul(ff_coef[k], taps[k-1]));
      acc = clip32(acc + fmul(ff_coef[4], taps[3]));
      y = clip16(round_high(acc) * 2);
      // advance the delay line
      taps[3] = taps[2];
      taps[2] = taps[1];
      taps[1] = taps[0];
      taps[0] = w[iir4_pkg::SampleWidth-1:0];
      expected_q.push_back(y[iir4_pkg::SampleWidth-1:0]);
   endfunction

   function void check_output(logic signed [iir4_pkg::SampleWidth-1:0] got);
      logic signed [iir4_pkg::SampleWidth-1:0] want;
      if (expected_q.size() == 0) begin
         $error("sample_out: unexpected transaction, expected none, actual %0d", got);
         errors++;
      end else begin
         want = expected_q.pop_front();
         if (got !== want) begin
            $error("sample_out mismatch: expected %0d, actual %0d", want, got);
            errors++;
         end
      end
   endfunction

   function int pending();
      return expected_q.size();
   endfunction
endclass

module tb;
   localparam logic [iir4_pkg::CsrIdxWidth-1:0] CSR_UNUSED = 2'd3;
   localparam int LIMIT_CYCLES = 600000;
   localparam int MAX_GAP      = 11;
   localparam int STALL_CYCLES = 400;
   localparam int STALL_AT     = 900;
   localparam int PHASE_ITEMS  = 153;
   localparam int NUM_PHASES   = 10;

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             csr_we;
   logic [iir4_pkg::CsrIdxWidth-1:0] csr_index;
   logic [iir4_pkg::CsrWidth-1:0]    csr_wdata;

   iir4_req_if req_ch ();
   iir4_rsp_if rsp_ch ();

   df2_tracker_type board;
   bit              no_idle = 1'b0;
   int unsigned     cycle_count = 0;
   int unsigned     outputs_seen = 0;

   iir_fourth_order_df2_q15 uut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Abort a run that hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic int draw_gap();
      return no_idle ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   function automatic logic signed [iir4_pkg::CoeffWidth-1:0] rand_coeff(
      coef_mode_type mode);
      case (mode)
         COEF_MAX:  return 16'sh7FFF;
         COEF_MIN:  return 16'sh8000;
         COEF_ZERO: return '0;
         COEF_WIDE: return 16'($urandom);
         default:   return 16'($urandom_range(0, 8191) - 4096);
      endcase
   endfunction

   function automatic logic [iir4_pkg::CsrWidth-1:0] pack_coeffs(coef_mode_type mode);
      logic [iir4_pkg::CsrWidth-1:0] word;
      for (int k = 0; k < 4; k++) word[16*k +: 16] = rand_coeff(mode);
      return word;
   endfunction

   function automatic logic signed [iir4_pkg::SampleWidth-1:0] rand_sample();
      case ($urandom_range(0, 9))
         6:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         7:       return 16'($urandom_range(0, 511) - 256);
         8:       return '0;
         9:       return -16'sd1;
         default: return 16'($urandom);
      endcase
   endfunction

   // Offer one sample after a random gap and hold it until taken
   task automatic send_sample(input logic signed [iir4_pkg::SampleWidth-1:0] x);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.sample_in <= x;
      do @(posedge clock); while (!req_ch.ready);
      board.note_sample(x);
   endtask

   // Drop valid and wait until every owed output is back
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [iir4_pkg::CsrIdxWidth-1:0] idx,
                            input logic [iir4_pkg::CsrWidth-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      board.write_reg(idx, data);
   endtask

   // Accept outputs with random stalls and one long hold-off
   task automatic receive_loop();
      int gap;
      forever begin
         gap = draw_gap();
         if (outputs_seen == STALL_AT) gap = STALL_CYCLES;
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid === 1'b1 && rsp_ch.ready));
         board.check_output(rsp_ch.sample_out);
         outputs_seen++;
      end
   endtask

   initial begin
      logic signed [iir4_pkg::SampleWidth-1:0] probes [11];
      logic [iir4_pkg::CsrWidth-1:0] junk;
      coef_mode_type                 fb_mode;
      coef_mode_type                 ff_mode;
      bit                            use_defaults;

      probes = '{
         16'sh0000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000,
         16'sh8000, 16'sh0001, 16'shFFFF, 16'sh5555, 16'shAAAA
      };
      reset            <= 1'b1;
      csr_we           <= 1'b0;
      csr_index        <= '0;
      csr_wdata        <= '0;
      req_ch.valid     <= 1'b0;
      req_ch.sample_in <= '0;
      rsp_ch.ready     <= 1'b0;
      board = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      fork
         receive_loop();
      join_none

      // Field extremes with the default coefficients
      foreach (probes[i]) send_sample(probes[i]);
      drain();

      // Most negative coefficients drive every saturation path; also
      // junk above the last register and a write to the unused index
      csr_write(iir4_pkg::CSR_FEEDBACK, {4{16'h8000}});
      csr_write(iir4_pkg::CSR_FORWARD_LOW, {4{16'h8000}});
      csr_write(iir4_pkg::CSR_FORWARD_LAST, {48'hA5A5_F00D_3C3C, 16'h8000});
      csr_write(CSR_UNUSED, 64'h7FFF_7FFF_7FFF_7FFF);
      repeat (5) send_sample(16'sh8000);
      repeat (4) send_sample(16'sh7FFF);
      send_sample(16'sh0000);
      send_sample(16'sh8000);
      send_sample(16'sh7FFF);
      drain();

      // Random samples over a series of coefficient settings
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         use_defaults = 1'b0;
         case (phase)
            0: begin fb_mode = COEF_MAX;  ff_mode = COEF_MAX;  end
            1: begin fb_mode = COEF_MIN;  ff_mode = COEF_MIN;  end
            2: begin fb_mode = COEF_ZERO; ff_mode = COEF_WIDE; end
            3: begin fb_mode = COEF_MILD; ff_mode = COEF_MILD; end
            4: begin fb_mode = COEF_WIDE; ff_mode = COEF_WIDE; end
            5: begin fb_mode = COEF_MILD; ff_mode = COEF_MILD; use_defaults = 1'b1; end
            default: begin
               fb_mode = coef_mode_type'($urandom_range(0, 4));
               ff_mode = coef_mode_type'($urandom_range(0, 4));
            end
         endcase
         junk = {$urandom, $urandom};
         if (use_defaults) begin
            csr_write(iir4_pkg::CSR_FEEDBACK, iir4_pkg::FEEDBACK_RESET);
            csr_write(iir4_pkg::CSR_FORWARD_LOW, iir4_pkg::FORWARD_LOW_RESET);
            csr_write(iir4_pkg::CSR_FORWARD_LAST,
                      {junk[iir4_pkg::CsrWidth-1:16], iir4_pkg::FORWARD_LAST_RESET});
         end else begin
            csr_write(iir4_pkg::CSR_FEEDBACK, pack_coeffs(fb_mode));
            csr_write(iir4_pkg::CSR_FORWARD_LOW, pack_coeffs(ff_mode));
            csr_write(iir4_pkg::CSR_FORWARD_LAST,
                      {junk[iir4_pkg::CsrWidth-1:16], rand_coeff(ff_mode)});
         end
         if (phase % 2 == 1) csr_write(CSR_UNUSED, {$urandom, $urandom});
         no_idle = (phase == 3 || phase == 7);
         repeat (PHASE_ITEMS) send_sample(rand_sample());
         drain();
      end

      // Let the pipeline settle before the verdict
      repeat (60) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
